FILE: rtl/stsolve_pkg.sv
// ----------------------------------------------------------------------------
// stsolve_pkg
// Types and fixed constants shared by the sparse triangular solve unit.
// ----------------------------------------------------------------------------
package stsolve_pkg;

   localparam int VAL_W   = 32;
   localparam int FRAC_W  = 24;
   localparam int IDX_W   = 13;
   localparam int ROW_W   = 12;
   localparam int STAT_W  = 2;

   // The divider shifts the scaled accumulator through one quotient bit per step.
   localparam int DQ_W      = VAL_W + FRAC_W;
   localparam int DIV_CNT_W = $clog2(DQ_W + 1);

   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_SAT       = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_ZERO_DIAG = 2'd2;

   typedef struct packed {
      logic signed [VAL_W-1:0] rhs_value;
      logic signed [VAL_W-1:0] coefficient;
      logic [IDX_W-1:0]        neighbor_index;
      logic                    first_of_row;
      logic                    last_of_row;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]        row_index;
      logic signed [VAL_W-1:0] solution;
      logic [STAT_W-1:0]       status;
   } rsp_type;

   typedef struct packed {
      logic load_item;
      logic map_step;
      logic row_open;
      logic rd_en;
      logic mul;
      logic acc;
      logic div_start;
      logic div_step;
      logic div_finish;
      logic zero_finish;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic map_done;
      logic first;
      logic last;
      logic diag_zero;
      logic div_done;
   } dp_status_type;

endpackage

FILE: rtl/stsolve_ram.sv
// ----------------------------------------------------------------------------
// stsolve_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module stsolve_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/stsolve_ctrl.sv
// ----------------------------------------------------------------------------
// stsolve_ctrl
// Sequencer for the solve unit: maps each item's index, then opens a row or
// does store read, multiply, accumulate; closes rows via divider or zero path.
// ----------------------------------------------------------------------------
module stsolve_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output stsolve_pkg::ctrl_cmd_type  cmd,
   input  stsolve_pkg::dp_status_type sts
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_MAP      = 3'd1;
   localparam logic [2:0] ST_MUL      = 3'd2;
   localparam logic [2:0] ST_ACC      = 3'd3;
   localparam logic [2:0] ST_DIV_INIT = 3'd4;
   localparam logic [2:0] ST_DIV_RUN  = 3'd5;
   localparam logic [2:0] ST_EMIT     = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_MAP;
            end
         end
         ST_MAP: begin
            if (!sts.map_done) begin
               cmd.map_step = 1'b1;
            end else if (sts.first) begin
               cmd.row_open = 1'b1;
               state_in     = sts.last ? ST_DIV_INIT : ST_IDLE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = sts.last ? ST_DIV_INIT : ST_IDLE;
         end
         ST_DIV_INIT: begin
            if (sts.diag_zero) begin
               cmd.zero_finish = 1'b1;
               state_in        = ST_EMIT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_RUN;
            end
         end
         ST_DIV_RUN: begin
            if (sts.div_done) begin
               cmd.div_finish = 1'b1;
               state_in       = ST_EMIT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/stsolve_datapath.sv
// ----------------------------------------------------------------------------
// stsolve_datapath
// Item registers, index reduction, solution store, multiply-accumulate,
// restoring divider and the result register of the solve unit.
// ----------------------------------------------------------------------------
module stsolve_datapath #(
   parameter int STORE_DEPTH = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  stsolve_pkg::req_type       req_data,
   input  stsolve_pkg::ctrl_cmd_type  cmd,
   output stsolve_pkg::dp_status_type sts,
   output stsolve_pkg::rsp_type       rsp_data
);

   localparam int VW        = stsolve_pkg::VAL_W;
   localparam int RW        = stsolve_pkg::ROW_W;
   localparam int DQW       = stsolve_pkg::DQ_W;
   localparam int CW        = stsolve_pkg::DIV_CNT_W;
   localparam int AW        = $clog2(STORE_DEPTH);
   localparam int IDX_SPAN  = 2 ** stsolve_pkg::IDX_W;
   localparam int XW        = $clog2(IDX_SPAN + STORE_DEPTH);
   localparam bit IS_POW2   = (STORE_DEPTH & (STORE_DEPTH - 1)) == 0;
   localparam int MAP_STEPS = IS_POW2 ? 0 : 2;
   localparam int SW        = $clog2(MAP_STEPS + 2);
   localparam logic [XW-1:0] DEPTH_X = XW'(STORE_DEPTH);
   localparam logic [XW-1:0] BIAS_X  = XW'(STORE_DEPTH - 1);

   // The quotient of the biased index by the depth comes from a multiply by
   // a rounded-up reciprocal, exact for every index that fits in XW bits.
   localparam int     RCP_SHIFT = XW + AW;
   localparam int     RCP_W     = XW + 1;
   localparam int     PW        = XW + RCP_W;
   localparam longint RCP_FULL  = ((longint'(1) <<< RCP_SHIFT) + longint'(STORE_DEPTH) - 1)
                                  / longint'(STORE_DEPTH);
   localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_FULL);

   localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (stsolve_pkg::FRAC_W - 1);
   localparam logic signed [64:0] LIM_HI     = 65'sd2147483647;
   localparam logic signed [64:0] LIM_LO     = -65'sd2147483648;
   localparam logic [DQW-1:0]     POS_LIM    = DQW'(32'h7FFF_FFFF);
   localparam logic [DQW-1:0]     NEG_LIM    = DQW'(32'h8000_0000);

   logic signed [VW-1:0] rhs_ff, coef_ff;
   logic                 first_ff, last_ff;
   logic [XW-1:0]        map_ff, map_in;
   logic [SW-1:0]        map_step_ff, map_step_in;
   logic [XW-1:0]        quot_ff, quot_in;

   logic signed [VW-1:0] acc_ff, acc_in;
   logic signed [VW-1:0] diag_ff, diag_in;
   logic [AW-1:0]        row_ff, row_in;
   logic                 sat_ff, sat_in;
   logic signed [63:0]   prod_ff;

   logic [DQW-1:0]       dq_ff, dq_in;
   logic [VW-1:0]        rem_ff, rem_in;
   logic [VW-1:0]        dvs_ff;
   logic                 neg_ff;
   logic [CW-1:0]        cnt_ff, cnt_in;

   logic signed [VW-1:0] sol_ff, sol_in;
   logic [1:0]           stat_ff, stat_in;
   stsolve_pkg::rsp_type rsp_ff;

   logic signed [VW-1:0] rd_data;

   logic [PW-1:0]        rcp_prod;
   logic signed [63:0]   term;
   logic signed [64:0]   diff;
   logic [VW:0]          trial;
   logic                 trial_ge;
   logic                 q_sat;
   logic [VW-1:0]        acc_mag, diag_mag;

   stsolve_ram #(
      .WIDTH(VW),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (cmd.emit),
      .wr_addr(row_ff),
      .wr_data(sol_ff),
      .rd_en  (cmd.rd_en),
      .rd_addr(map_ff[AW-1:0]),
      .rd_data(rd_data)
   );

   always_comb begin
      rcp_prod    = PW'(map_ff) * PW'(RCP);
      map_in      = map_ff;
      map_step_in = map_step_ff;
      quot_in     = quot_ff;
      if (cmd.load_item) begin
         map_in      = XW'(req_data.neighbor_index) + BIAS_X;
         map_step_in = SW'(MAP_STEPS);
      end else if (cmd.map_step) begin
         if (map_step_ff == SW'(1)) begin
            map_in = map_ff - quot_ff * DEPTH_X;
         end else begin
            quot_in = XW'(rcp_prod >> RCP_SHIFT);
         end
         map_step_in = map_step_ff - SW'(1);
      end
   end

   always_comb begin
      term     = (prod_ff + ROUND_HALF) >>> stsolve_pkg::FRAC_W;
      diff     = {{33{acc_ff[VW-1]}}, acc_ff} - {term[63], term};
      acc_mag  = acc_ff[VW-1] ? (~acc_ff + VW'(1)) : acc_ff;
      diag_mag = diag_ff[VW-1] ? (~diag_ff + VW'(1)) : diag_ff;
      trial    = {rem_ff, dq_ff[DQW-1]};
      trial_ge = trial >= {1'b0, dvs_ff};
      q_sat    = neg_ff ? (dq_ff > NEG_LIM) : (dq_ff > POS_LIM);

      acc_in  = acc_ff;
      diag_in = diag_ff;
      row_in  = row_ff;
      sat_in  = sat_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      sol_in  = sol_ff;
      stat_in = stat_ff;

      if (cmd.row_open) begin
         acc_in  = rhs_ff;
         diag_in = coef_ff;
         row_in  = map_ff[AW-1:0];
         sat_in  = 1'b0;
      end
      if (cmd.acc) begin
         if (diff > LIM_HI) begin
            acc_in = stsolve_pkg::VAL_MAX;
            sat_in = 1'b1;
         end else if (diff < LIM_LO) begin
            acc_in = stsolve_pkg::VAL_MIN;
            sat_in = 1'b1;
         end else begin
            acc_in = diff[VW-1:0];
         end
      end
      if (cmd.div_start) begin
         dq_in  = {acc_mag, {stsolve_pkg::FRAC_W{1'b0}}};
         rem_in = '0;
         cnt_in = CW'(DQW);
      end
      if (cmd.div_step) begin
         rem_in = trial_ge ? VW'(trial - {1'b0, dvs_ff}) : trial[VW-1:0];
         dq_in  = {dq_ff[DQW-2:0], trial_ge};
         cnt_in = cnt_ff - CW'(1);
      end
      if (cmd.div_finish) begin
         if (q_sat) begin
            sol_in = neg_ff ? stsolve_pkg::VAL_MIN : stsolve_pkg::VAL_MAX;
         end else begin
            sol_in = neg_ff ? (~dq_ff[VW-1:0] + VW'(1)) : dq_ff[VW-1:0];
         end
         sat_in  = sat_ff | q_sat;
         stat_in = (sat_ff | q_sat) ? stsolve_pkg::STATUS_SAT : stsolve_pkg::STATUS_OK;
      end
      if (cmd.zero_finish) begin
         sol_in  = acc_ff[VW-1] ? stsolve_pkg::VAL_MIN : stsolve_pkg::VAL_MAX;
         stat_in = stsolve_pkg::STATUS_ZERO_DIAG;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         diag_ff <= '0;
         row_ff  <= '0;
         sat_ff  <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         diag_ff <= diag_in;
         row_ff  <= row_in;
         sat_ff  <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         rhs_ff   <= req_data.rhs_value;
         coef_ff  <= req_data.coefficient;
         first_ff <= req_data.first_of_row;
         last_ff  <= req_data.last_of_row;
      end
      if (cmd.mul) begin
         prod_ff <= coef_ff * rd_data;
      end
      if (cmd.div_start) begin
         dvs_ff <= diag_mag;
         neg_ff <= acc_ff[VW-1] ^ diag_ff[VW-1];
      end
      if (cmd.emit) begin
         rsp_ff.row_index <= RW'(row_ff);
         rsp_ff.solution  <= sol_ff;
         rsp_ff.status    <= stat_ff;
      end
      map_ff      <= map_in;
      map_step_ff <= map_step_in;
      quot_ff     <= quot_in;
      dq_ff       <= dq_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      sol_ff      <= sol_in;
      stat_ff     <= stat_in;
   end

   assign sts.map_done  = map_step_ff == '0;
   assign sts.first     = first_ff;
   assign sts.last      = last_ff;
   assign sts.diag_zero = diag_ff == '0;
   assign sts.div_done  = cnt_ff == '0;
   assign rsp_data      = rsp_ff;

endmodule

FILE: rtl/sparse_triangular_solve_unit.sv
// ----------------------------------------------------------------------------
// sparse_triangular_solve_unit
// Forward substitution against a sparse lower-triangular factor, one nonzero
// item at a time, with Q8.24 saturating arithmetic.
// ----------------------------------------------------------------------------
// Items are taken one at a time. An item that opens a row is accepted and
// opens the row, and an item that subtracts a product steps through accept,
// store read, multiply and accumulate; when STORE_DEPTH is not a power of two,
// index reduction adds a reciprocal multiply and a subtract. An item that
// closes a row then runs the restoring divider, which retires one of 56
// quotient bits per cycle, and the store write, or skips the divider when the
// diagonal is zero. The next item is accepted while a finished result waits on
// the result channel, but a second result waits until the first one is taken.
module sparse_triangular_solve_unit #(
   parameter int STORE_DEPTH = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  stsolve_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output stsolve_pkg::rsp_type rsp_data
);

   stsolve_pkg::ctrl_cmd_type  cmd;
   stsolve_pkg::dp_status_type sts;

   stsolve_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd      (cmd),
      .sts      (sts)
   );

   stsolve_datapath #(
      .STORE_DEPTH(STORE_DEPTH)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .req_data(req_data),
      .cmd     (cmd),
      .sts     (sts),
      .rsp_data(rsp_data)
   );

endmodule

FILE: rtl/stsolve_checker.sv
// ----------------------------------------------------------------------------
// stsolve_checker
// Port-level checks for the sparse triangular solve unit, bound to the top.
// ----------------------------------------------------------------------------
module stsolve_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input stsolve_pkg::rsp_type rsp_data
);

   // A waiting result must hold until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   // Items are worked one at a time, so ready drops right after an accept.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while another item is at work");

   a_zero_diag_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == stsolve_pkg::STATUS_ZERO_DIAG |->
         rsp_data.solution == stsolve_pkg::VAL_MAX ||
         rsp_data.solution == stsolve_pkg::VAL_MIN)
      else $error("zero diagonal result is not saturated");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

endmodule

bind sparse_triangular_solve_unit stsolve_checker u_checker (.*);
